>>> hdl/pvq_pkg.sv
// pvq_pkg: shared constants, types and helper functions of the phase vq search
// no dependencies; imported by pvq_front, pvq_back and phase_vq_nearest_search
`timescale 1ns / 1ps

package pvq_pkg;

  // sizes
  localparam int unsigned MAX_DIM      = 64;
  localparam int unsigned MAX_ENTRIES  = 1024;
  localparam int unsigned CORDIC_STEPS = 14;
  localparam int unsigned ATAN_LEN     = 20;
  localparam int unsigned STEPS        = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  // fixed field widths
  localparam int unsigned ENTRY_W = 10;
  localparam int unsigned ELEM_W  = 6;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned ERR_W   = 34;
  localparam int unsigned DIMR_W  = 7;
  localparam int unsigned ENTR_W  = 11;
  localparam int unsigned DATA_W  = 48;

  // derived widths
  localparam int unsigned IDX_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DCNT_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned CB_DEPTH = MAX_ENTRIES * MAX_DIM;
  localparam int unsigned CB_AW    = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1;

  // cordic datapath
  localparam int unsigned XY_W        = 36;
  localparam int unsigned Z_W         = 16;
  localparam int signed   HALF_PI_Q12 = 6434;

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  // input queue
  localparam int unsigned QD     = 4;
  localparam int unsigned QPTR_W = $clog2(QD);
  localparam int unsigned QCNT_W = $clog2(QD + 1);

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic {
    REG_DIM = 1'b0,
    REG_ENT = 1'b1
  } reg_e;

  typedef struct packed {
    req_e                      kind;
    logic                      skip;   // query that adds nothing
    logic                      last;
    logic [ENTRY_W-1:0]        entry;
    logic [ELEM_W-1:0]         elem;
    logic signed [VAL_W-1:0]   re;
    logic signed [VAL_W-1:0]   im;
  } item_t;

  function automatic logic [DCNT_W-1:0] clamp_dim(input logic [DIMR_W-1:0] v);
    logic [DCNT_W-1:0] r;
    if (v == '0) r = DCNT_W'(1);
    else if (32'(v) > MAX_DIM) r = DCNT_W'(MAX_DIM);
    else r = DCNT_W'(v);
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_ent(input logic [ENTR_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) r = CNT_W'(1);
    else if (32'(v) > MAX_ENTRIES) r = CNT_W'(MAX_ENTRIES);
    else r = CNT_W'(v);
    return r;
  endfunction

  // atan(2^-k) in q12 radians, rounded to nearest
  function automatic logic [11:0] atan_q12(input int unsigned k);
    logic [11:0] r;
    case (k)
      0:  r = 12'd3217;
      1:  r = 12'd1899;
      2:  r = 12'd1003;
      3:  r = 12'd509;
      4:  r = 12'd256;
      5:  r = 12'd128;
      6:  r = 12'd64;
      7:  r = 12'd32;
      8:  r = 12'd16;
      9:  r = 12'd8;
      10: r = 12'd4;
      11: r = 12'd2;
      12: r = 12'd1;
      default: r = 12'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/pvq_front.sv
// pvq_front: input acceptance, item classification and a short item queue
// depends on pvq_pkg
`timescale 1ns / 1ps

module pvq_front import pvq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_kind_i,
  input  logic                in_last_i,
  input  logic [DATA_W-1:0]   in_data_i,   // entry, element, real, imag
  input  logic [DCNT_W-1:0]   n_dim_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output item_t               item_o
);

  item_t             cls;
  item_t             q_mem [QD];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  // classify on the way in
  always_comb begin
    cls.kind  = req_e'(in_kind_i);
    cls.last  = in_last_i & (in_kind_i == REQ_QUERY);
    cls.entry = in_data_i[9:0];
    cls.elem  = in_data_i[15:10];
    cls.re    = in_data_i[31:16];
    cls.im    = in_data_i[47:32];
    cls.skip  = (DCNT_W'(cls.elem) >= n_dim_i) || ((cls.re == '0) && (cls.im == '0));
  end

  assign in_ready_o   = (cnt_q != QCNT_W'(QD));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_mem[rptr_q];
  assign push         = in_valid_i & in_ready_o;
  assign pop          = item_valid_o & item_ready_i;

  always_comb begin
    wptr_d = push ? QPTR_W'(wptr_q + 1'b1) : wptr_q;
    rptr_d = pop  ? QPTR_W'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wptr_q] <= cls;
  end

  queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QD)) else $error("item queue overflow");

  queue_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)))
    else $error("item queue count lost a push");

  queue_pop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (rptr_q == QPTR_W'($past(rptr_q) + 1'b1)))
    else $error("item queue read pointer did not advance");

endmodule

>>> hdl/pvq_back.sv
// pvq_back: codebook memory, product and cordic pipeline, error accumulators,
// minimum search and result register; depends on pvq_pkg
`timescale 1ns / 1ps

module pvq_back import pvq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  item_t              item_i,
  input  logic [CNT_W-1:0]   n_ent_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [ENTRY_W-1:0] res_index_o,
  output logic [ERR_W-1:0]   res_error_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SWEEP  = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_SEARCH = 6'b001000,
    ST_SFIN   = 6'b010000,
    ST_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [IDX_W-1:0]        j_q;
  logic [CNT_W-1:0]        n_ent_q, fill_q;
  logic [ELEM_W-1:0]       elem_q;
  logic signed [VAL_W-1:0] qr_q, qi_q;
  logic                    last_q;
  logic                    take, cnt_end, pipe_busy, res_load;

  // codebook memory
  logic [31:0]       cb_mem [CB_DEPTH];
  logic [31:0]       cb_rd_q;
  logic              cb_we;
  logic [CB_AW-1:0]  cb_waddr, cb_raddr;

  // pipeline
  logic                    p0_v_q, p1_v_q, sq_v_q;
  logic [IDX_W-1:0]        p0_j_q, p1_j_q, sq_j_q;
  logic signed [31:0]      ar_q, bi_q, br_q, ai_q;
  logic signed [VAL_W-1:0] cb_a, cb_b;
  logic signed [XY_W-1:0]  pr_w, pi_w, x0, y0;
  logic signed [Z_W-1:0]   z0, zf;
  logic [STEPS:0]          c_v_q, c_zero_q;
  logic signed [XY_W-1:0]  c_x_q [STEPS+1];
  logic signed [XY_W-1:0]  c_y_q [STEPS+1];
  logic signed [Z_W-1:0]   c_z_q [STEPS+1];
  logic [IDX_W-1:0]        c_j_q [STEPS+1];
  logic [2*Z_W-1:0]        sq_q;

  // accumulators
  logic [ERR_W-1:0]  acc_mem [MAX_ENTRIES];
  logic [ERR_W-1:0]  acc_rd_q, acc_old, acc_wd;
  logic [ERR_W:0]    acc_sum;
  logic [IDX_W-1:0]  acc_raddr;

  // search
  logic              srch_v_q;
  logic [IDX_W-1:0]  srch_idx_q, best_idx_q;
  logic [ERR_W-1:0]  srch_val, best_err_q;

  logic                res_v_q;
  logic [ENTRY_W-1:0]  res_idx_q;
  logic [ERR_W-1:0]    res_err_q;

  assign item_ready_o = (state_q == ST_IDLE);
  assign take         = item_valid_i & item_ready_o;
  assign cnt_end      = (CNT_W'(j_q) == n_ent_q - CNT_W'(1));
  assign pipe_busy    = p0_v_q | p1_v_q | (|c_v_q) | sq_v_q;
  assign res_load     = (state_q == ST_OUT) && (!res_v_q || res_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take && item_i.kind == REQ_QUERY) begin
          if (!item_i.skip) state_d = ST_SWEEP;
          else if (item_i.last) state_d = ST_SEARCH;
        end
      end
      ST_SWEEP:  if (cnt_end) state_d = ST_DRAIN;
      ST_DRAIN: begin
        if (!pipe_busy) state_d = last_q ? ST_SEARCH : ST_IDLE;
      end
      ST_SEARCH: if (cnt_end) state_d = ST_SFIN;
      ST_SFIN:   state_d = ST_OUT;
      ST_OUT:    if (res_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q     <= '0;
      fill_q  <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SWEEP || state_q == ST_SEARCH) j_q <= IDX_W'(j_q + 1'b1);
      else j_q <= '0;
      if (state_q == ST_DRAIN && !pipe_busy && n_ent_q > fill_q) fill_q <= n_ent_q;
      else if (res_load) fill_q <= '0;
      if (res_load) res_v_q <= 1'b1;
      else if (res_ready_i) res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.kind == REQ_QUERY) begin
      elem_q  <= item_i.elem;
      qr_q    <= item_i.re;
      qi_q    <= item_i.im;
      last_q  <= item_i.last;
      n_ent_q <= n_ent_i;
    end
    if (res_load) begin
      res_idx_q <= ENTRY_W'(best_idx_q);
      res_err_q <= best_err_q;
    end
  end

  // codebook ports: loads write, sweeps read
  assign cb_we    = take && (item_i.kind == REQ_LOAD)
                    && (32'(item_i.entry) < MAX_ENTRIES) && (32'(item_i.elem) < MAX_DIM);
  assign cb_waddr = CB_AW'(32'(item_i.entry) * MAX_DIM + 32'(item_i.elem));
  assign cb_raddr = CB_AW'(32'(j_q) * MAX_DIM + 32'(elem_q));

  always_ff @(posedge clk_i) begin
    if (cb_we) cb_mem[cb_waddr] <= {item_i.re, item_i.im};
    cb_rd_q <= cb_mem[cb_raddr];
  end

  // product of codeword and conjugate query
  assign cb_a = cb_rd_q[31:16];
  assign cb_b = cb_rd_q[15:0];

  always_ff @(posedge clk_i) begin
    p0_j_q <= j_q;
    p1_j_q <= p0_j_q;
    ar_q   <= cb_a * qr_q;
    bi_q   <= cb_b * qi_q;
    br_q   <= cb_b * qr_q;
    ai_q   <= cb_a * qi_q;
  end

  // quadrant fold into the right half plane
  always_comb begin
    pr_w = XY_W'(ar_q) + XY_W'(bi_q);
    pi_w = XY_W'(br_q) - XY_W'(ai_q);
    if (pr_w < 0) begin
      if (pi_w >= 0) begin
        x0 = pi_w;
        y0 = -pr_w;
        z0 = Z_W'(HALF_PI_Q12);
      end else begin
        x0 = -pi_w;
        y0 = pr_w;
        z0 = -Z_W'(HALF_PI_Q12);
      end
    end else begin
      x0 = pr_w;
      y0 = pi_w;
      z0 = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    c_x_q[0]    <= x0;
    c_y_q[0]    <= y0;
    c_z_q[0]    <= z0;
    c_zero_q[0] <= (pr_w == '0) && (pi_w == '0);
    c_j_q[0]    <= p1_j_q;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_cordic
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  at;
    assign xs = c_x_q[k] >>> k;
    assign ys = c_y_q[k] >>> k;
    assign at = Z_W'(atan_q12(k));
    always_ff @(posedge clk_i) begin
      if (c_y_q[k] > 0) begin
        c_x_q[k+1] <= c_x_q[k] + ys;
        c_y_q[k+1] <= c_y_q[k] - xs;
        c_z_q[k+1] <= c_z_q[k] + at;
      end else begin
        c_x_q[k+1] <= c_x_q[k] - ys;
        c_y_q[k+1] <= c_y_q[k] + xs;
        c_z_q[k+1] <= c_z_q[k] - at;
      end
      c_zero_q[k+1] <= c_zero_q[k];
      c_j_q[k+1]    <= c_j_q[k];
    end
  end

  // square of the angle, zero product gives zero
  assign zf = c_zero_q[STEPS] ? '0 : c_z_q[STEPS];

  always_ff @(posedge clk_i) begin
    sq_q   <= unsigned'((2*Z_W)'(zf) * (2*Z_W)'(zf));
    sq_j_q <= c_j_q[STEPS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q   <= 1'b0;
      p1_v_q   <= 1'b0;
      c_v_q    <= '0;
      sq_v_q   <= 1'b0;
      srch_v_q <= 1'b0;
    end else begin
      p0_v_q   <= (state_q == ST_SWEEP);
      p1_v_q   <= p0_v_q;
      c_v_q    <= {c_v_q[STEPS-1:0], p1_v_q};
      sq_v_q   <= c_v_q[STEPS];
      srch_v_q <= (state_q == ST_SEARCH);
    end
  end

  // accumulate; entries past the fill count read as zero
  assign acc_old   = (CNT_W'(sq_j_q) < fill_q) ? acc_rd_q : '0;
  assign acc_sum   = {1'b0, acc_old} + (ERR_W+1)'(sq_q);
  assign acc_wd    = acc_sum[ERR_W] ? ERR_MAX : acc_sum[ERR_W-1:0];
  assign acc_raddr = (state_q == ST_SEARCH) ? j_q : c_j_q[STEPS];

  always_ff @(posedge clk_i) begin
    if (sq_v_q) acc_mem[sq_j_q] <= acc_wd;
    acc_rd_q <= acc_mem[acc_raddr];
  end

  // minimum search, one entry a cycle, first smallest wins
  assign srch_val = (CNT_W'(srch_idx_q) < fill_q) ? acc_rd_q : '0;

  always_ff @(posedge clk_i) begin
    srch_idx_q <= j_q;
    if (srch_v_q && (srch_idx_q == '0 || srch_val < best_err_q)) begin
      best_idx_q <= srch_idx_q;
      best_err_q <= srch_val;
    end
  end

  assign res_valid_o = res_v_q;
  assign res_index_o = res_idx_q;
  assign res_error_o = res_err_q;

  search_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> !pipe_busy)
    else $error("search started with accumulator updates in flight");

  fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_ENTRIES)) else $error("fill count beyond entry count");

  result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_v_q) |-> $past(state_q == ST_OUT))
    else $error("result register loaded outside the output state");

endmodule

>>> hdl/phase_vq_nearest_search.sv
// phase_vq_nearest_search: top level with stream ports and register port
// depends on pvq_pkg, pvq_front and pvq_back
`timescale 1ns / 1ps

// usage
//   input stream: tuser 0 loads one complex codebook element, tuser 1 is a
//   query element; tlast on a query element closes the vector
//   output stream: one transaction per closed vector with the best entry and
//   its summed squared phase error (q24, saturating)
//   register port: dim_in_use at 0x0, entries_in_use at 0x4, write only while idle
// timing
//   a load is written in the back end without leaving the idle state
//   a query element that contributes makes one codebook read and one
//   accumulator update per entry, then waits while the product, cordic and
//   square pipeline drains
//   a closing element adds a minimum search over the accumulator memory,
//   one entry per cycle, before the result shows
// reset
//   registers return to dim 16 and 64 entries, accumulators read as zero
//   through a fill count, codebook contents stay undefined until loaded
// stalls
//   a four-deep queue keeps taking input while the back end works; a stalled
//   result holds in the output register and blocks only the next vector end

module phase_vq_nearest_search import pvq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [47:0]       s_axis_tdata,  // entry_index, element_index, real_part, imag_part
  input  logic              s_axis_tuser,  // req_type
  input  logic              s_axis_tlast,  // last_element
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,  // best_index, min_error, zero pad
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [DIMR_W-1:0]  dim_q;
  logic [ENTR_W-1:0]  ent_q;
  logic               cfg_wr;
  reg_e               cfg_idx;

  logic               item_valid, item_ready;
  item_t              item;
  logic [ENTRY_W-1:0] res_index;
  logic [ERR_W-1:0]   res_error;

  // register port, zero wait states
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIMR_W'(16);
      ent_q <= ENTR_W'(64);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DIM: dim_q <= pwdata[DIMR_W-1:0];
        REG_ENT: ent_q <= pwdata[ENTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DIM: prdata = 32'(dim_q);
      REG_ENT: prdata = 32'(ent_q);
      default: prdata = '0;
    endcase
  end

  // front end: accept and classify into the item queue
  pvq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .in_data_i    (s_axis_tdata),
    .n_dim_i      (clamp_dim(dim_q)),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // back end: memories, pipeline and search
  pvq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .n_ent_i      (clamp_ent(ent_q)),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_index_o  (res_index),
    .res_error_o  (res_error)
  );

  assign m_axis_tdata = {4'b0, res_error, res_index};

endmodule

>>> test/phase_vq_nearest_search_checker.sv
// phase_vq_nearest_search_checker: watches the stream and register ports of the
// phase vq search, predicts each best-entry result and compares; uses pvq_pkg
`timescale 1ns / 1ps

module phase_vq_nearest_search_checker import pvq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [ENTRY_W-1:0] idx;
    logic [ERR_W-1:0]   err;
  } best_t;

  localparam longint ATAN_TAB [20] = '{3217, 1899, 1003, 509, 256, 128, 64, 32, 16, 8,
                                       4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

  logic [31:0]      cb_words [MAX_ENTRIES*MAX_DIM];
  logic [ERR_W-1:0] err_sums [MAX_ENTRIES];
  logic [DIMR_W-1:0] dim_reg;
  logic [ENTR_W-1:0] ent_reg;
  best_t            best_q [$];

  // q12 angle of (y, x) by shift-and-add rotation; origin gives zero
  function automatic longint phase_q12(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q12;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q12;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  task automatic take_item(logic [47:0] d, logic kind, logic last);
    logic [ENTRY_W-1:0] ent;
    logic [ELEM_W-1:0]  el;
    longint qr, qi, a, b, ang, sq, acc;
    int n_ent, n_dim, bi;
    best_t r;
    ent = d[9:0];
    el  = d[15:10];
    qr  = longint'($signed(d[31:16]));
    qi  = longint'($signed(d[47:32]));
    if (kind == REQ_LOAD) begin
      cb_words[ent*MAX_DIM + el] = {d[31:16], d[47:32]};
      return;
    end
    n_ent = (ent_reg == 0) ? 1 : (ent_reg > MAX_ENTRIES) ? MAX_ENTRIES : ent_reg;
    n_dim = (dim_reg == 0) ? 1 : (dim_reg > MAX_DIM) ? MAX_DIM : dim_reg;
    if (el < n_dim && !(qr == 0 && qi == 0)) begin
      for (int j = 0; j < n_ent; j++) begin
        a = longint'($signed(cb_words[j*MAX_DIM + el][31:16]));
        b = longint'($signed(cb_words[j*MAX_DIM + el][15:0]));
        // codeword times conjugate of the query element
        ang = phase_q12(b*qr - a*qi, a*qr + b*qi);
        sq = ang * ang;
        acc = longint'(err_sums[j]) + sq;
        err_sums[j] = (acc > longint'(ERR_MAX)) ? ERR_MAX : acc[ERR_W-1:0];
      end
    end
    if (!last) return;
    bi = 0;
    for (int j = 1; j < n_ent; j++)
      if (err_sums[j] < err_sums[bi]) bi = j;
    r.idx = bi[ENTRY_W-1:0];
    r.err = err_sums[bi];
    best_q.push_back(r);
    foreach (err_sums[j]) err_sums[j] = '0;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    dim_reg = 7'd16;
    ent_reg = 11'd64;
    foreach (err_sums[j]) err_sums[j] = '0;
  end

  always @(posedge clk_i) begin
    best_t e;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(4*REG_DIM)) dim_reg = pwdata[DIMR_W-1:0];
        else if (paddr == 3'(4*REG_ENT)) ent_reg = pwdata[ENTR_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        take_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (best_q.size() == 0) begin
          $error("unexpected result transaction %h", m_axis_tdata);
          fail_count++;
        end else begin
          e = best_q.pop_front();
          if (m_axis_tdata[9:0] !== e.idx) begin
            $error("best_index expected %0d actual %0d", e.idx, m_axis_tdata[9:0]);
            fail_count++;
          end
          if (m_axis_tdata[43:10] !== e.err) begin
            $error("min_error expected %0d actual %0d", e.err, m_axis_tdata[43:10]);
            fail_count++;
          end
        end
      end
      pending = best_q.size();
    end
  end

endmodule

>>> test/phase_vq_nearest_search_tb.sv
// phase_vq_nearest_search_tb: stimulus and verdict for the phase vq search
// depends on pvq_pkg, phase_vq_nearest_search and phase_vq_nearest_search_checker
`timescale 1ns / 1ps

module phase_vq_nearest_search_tb import pvq_pkg::*; ();

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // entry_index, element_index, real_part, imag_part
  logic        s_axis_tuser = 1'b0; // req_type
  logic        s_axis_tlast = 1'b0; // last_element
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // best_index, min_error, zero pad
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;

  // tb view of which codebook words were loaded, so no query reads garbage
  bit [MAX_DIM-1:0] cb_loaded [MAX_ENTRIES];
  int  cur_dim = 16;
  int  cur_ent = 64;
  bit  quiet = 1'b0;       // no idling in the closing part
  bit  long_hold = 1'b0;   // receiver holds off for a long stretch

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  phase_vq_nearest_search DUT (.*);

  phase_vq_nearest_search_checker u_checker (.*);

  // timeout
  initial begin
    #20_000_000;
    $display("phase_vq_nearest_search_tb: FAIL");
    $finish;
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [15:0] rand_part();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transaction; tvalid stays high between back-to-back items
  task automatic send_item(logic kind, int ent, int el, logic [15:0] re, logic [15:0] im,
                           logic last);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {im, re, 6'(el), 10'(ent)};
    if (kind == REQ_LOAD) cb_loaded[ent][el] = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic load_word(int ent, int el);
    send_item(REQ_LOAD, ent, el, rand_part(), rand_part(), 1'($urandom));
  endtask

  // query element; zeroed when some searched entry lacks that element
  task automatic query_elem(int el, logic [15:0] re, logic [15:0] im, logic last);
    bit ok;
    ok = 1'b1;
    if (el < cur_dim)
      for (int j = 0; j < cur_ent; j++)
        if (!cb_loaded[j][el]) ok = 1'b0;
    if (!ok) begin
      re = '0;
      im = '0;
    end
    send_item(REQ_QUERY, $urandom_range(0, 1023), el, re, im, last);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_e r, logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4*r);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // change both registers once the back end has gone quiet
  task automatic set_shape(logic [31:0] dim, logic [31:0] ents);
    wait_drain();
    repeat (2*cur_ent + 60) @(posedge clk_i);
    reg_write(REG_DIM, dim);
    reg_write(REG_ENT, ents);
    cur_dim = (dim[6:0] == 0) ? 1 : (dim[6:0] > MAX_DIM) ? MAX_DIM : dim[6:0];
    cur_ent = (ents[10:0] == 0) ? 1 : (ents[10:0] > MAX_ENTRIES) ? MAX_ENTRIES : ents[10:0];
  endtask

  // mix of loads and well-formed vectors with random content
  task automatic random_phase(int n_items, bit pause_midway);
    int cnt, len, el;
    cnt = 0;
    while (cnt < n_items) begin
      if (pause_midway && cnt >= n_items/2) begin
        wait_drain();
        pause_midway = 1'b0;
      end
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 4) == 0) load_word($urandom_range(0, 1023), $urandom_range(0, 63));
        else load_word($urandom_range(0, cur_ent-1), $urandom_range(0, cur_dim-1));
        cnt++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? cur_dim + 2 :
              $urandom_range(1, (cur_dim < 6) ? cur_dim : 6);
        for (int k = 0; k < len; k++) begin
          el = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : k % MAX_DIM;
          query_elem(el, rand_part(), rand_part(), k == len-1);
          cnt++;
        end
      end
    end
  endtask

  initial begin
    foreach (cb_loaded[j]) cb_loaded[j] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset shape, sparse codebook
    random_phase(60, 1'b0);

    // directed: 4 elements, 3 entries, extreme values and special cases
    set_shape(4, 3);
    for (int j = 0; j < 3; j++)
      for (int k = 0; k < 4; k++)
        send_item(REQ_LOAD, j, k, (j == 0) ? 16'h8000 : (j == 1) ? 16'h7FFF : 16'h0001,
                  (k == 0) ? 16'h8000 : (k == 1) ? 16'h7FFF : 16'h0000, k == 3);
    send_item(REQ_LOAD, 1023, 63, 16'hFFFF, 16'hFFFF, 1'b1);
    query_elem(0, 16'h8000, 16'h8000, 1'b0);
    query_elem(1, 16'h7FFF, 16'h0000, 1'b0);
    query_elem(2, 16'h0000, 16'h0000, 1'b0);    // zero element adds nothing
    query_elem(3, 16'h0000, 16'h8000, 1'b1);
    query_elem(63, 16'h7FFF, 16'h7FFF, 1'b1);   // beyond dimension, still closes
    query_elem(2, 16'hFFFF, 16'h0001, 1'b1);    // query of -1 and +1 on element 2
    query_elem(0, 16'h0001, 16'h0000, 1'b1);

    // zero registers clamp to one element and one entry
    set_shape(0, 0);
    random_phase(60, 1'b0);

    // all-ones registers clamp to 64 elements and 1024 entries
    set_shape(127, 2047);
    random_phase(30, 1'b0);

    set_shape(64, 4);
    random_phase(110, 1'b1);

    // long receiver hold while vectors keep coming
    set_shape(7, 9);
    long_hold = 1'b1;
    random_phase(110, 1'b0);

    set_shape(2, 5);
    quiet = 1'b1;
    random_phase(190, 1'b0);

    wait_drain();
    repeat (2*cur_ent + 60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("phase_vq_nearest_search_tb: PASS");
    end else begin
      $display("phase_vq_nearest_search_tb: FAIL");
    end
    $finish;
  end

endmodule
